[sv/lnna_pkg.sv]
// Shared constants, types and tables for the landmark association block.
package lnna_pkg;

  localparam int ENTRIES_PER_COLOUR = 256;
  localparam int COLOUR_COUNT = 4;
  localparam int IDX_W = $clog2(ENTRIES_PER_COLOUR);
  localparam int CNT_W = IDX_W + 1;
  localparam int COL_W = (COLOUR_COUNT > 1) ? $clog2(COLOUR_COUNT) : 1;
  localparam int ADDR_W = COL_W + IDX_W;
  localparam int TABLE_DEPTH = COLOUR_COUNT * ENTRIES_PER_COLOUR;

  localparam int POS_W = 20;
  localparam int ANG_W = 16;
  localparam int RANGE_W = 17;
  localparam int THR_W = 16;
  localparam int WEIGHT_W = 17;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W = 34;
  localparam int STEP_W = 4;
  localparam int DIST_W = 43;
  localparam int LARGE_COLOUR = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd3;

  localparam logic [2:0] OUT_IGNORED = 3'd0;
  localparam logic [2:0] OUT_MATCHED = 3'd1;
  localparam logic [2:0] OUT_VERIFIED = 3'd2;
  localparam logic [2:0] OUT_NEW = 3'd3;
  localparam logic [2:0] OUT_FULL = 3'd4;

  localparam logic signed [CORDIC_W-1:0] CORDIC_ONE = 34'sd652032874;
  localparam logic signed [POS_W-1:0] POS_MAX = 20'sd524287;
  localparam logic signed [POS_W-1:0] POS_MIN = -20'sd524288;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic cordic_step;
    logic mul_x;
    logic mul_y;
    logic obs_fix;
    logic scan_issue;
    logic scan_eval;
    logic blend_mul;
    logic blend_fix;
    logic commit;
    logic out_load;
  } lnna_cmd_t;

  typedef struct packed {
    logic ignore;
    logic scan_done;
    logic full;
    logic out_busy;
  } lnna_status_t;

  function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [CORDIC_W-1:0] v;
    unique case (i)
      4'd0: v = 34'sh020000000;
      4'd1: v = 34'sh012E4051E;
      4'd2: v = 34'sh009FB385B;
      4'd3: v = 34'sh0051111D4;
      4'd4: v = 34'sh0028B0D43;
      4'd5: v = 34'sh00145D7E1;
      4'd6: v = 34'sh000A2F61E;
      4'd7: v = 34'sh000517C55;
      4'd8: v = 34'sh00028BE53;
      4'd9: v = 34'sh000145F2F;
      4'd10: v = 34'sh0000A2F98;
      4'd11: v = 34'sh0000517CC;
      4'd12: v = 34'sh000028BE6;
      4'd13: v = 34'sh0000145F3;
      4'd14: v = 34'sh00000A2FA;
      default: v = 34'sh00000517D;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [39:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 40'(POS_MAX)) r = POS_MAX;
    else if (v < 40'(POS_MIN)) r = POS_MIN;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

[sv/lnna_ram.sv]
// Generic single-port-write, registered-read RAM.
module lnna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/lnna_ctrl.sv]
// Sequencing state machine for the association block.
module lnna_ctrl
  import lnna_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  lnna_status_t status,
  output lnna_cmd_t    cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_CORDIC = 4'd2;
  localparam logic [3:0] S_MULX = 4'd3;
  localparam logic [3:0] S_MULY = 4'd4;
  localparam logic [3:0] S_OBS = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_DRAIN1 = 4'd7;
  localparam logic [3:0] S_DRAIN2 = 4'd8;
  localparam logic [3:0] S_BMUL = 4'd9;
  localparam logic [3:0] S_BFIX = 4'd10;
  localparam logic [3:0] S_COMMIT = 4'd11;
  localparam logic [3:0] S_OUT = 4'd12;

  logic [3:0] state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        step_next = '0;
        state_next = status.ignore ? S_OUT : S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        step_next = step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_next = S_OBS;
      end
      S_OBS: begin
        cmd.obs_fix = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        cmd.scan_eval = 1'b1;
        if (status.scan_done) state_next = S_DRAIN1;
      end
      S_DRAIN1: begin
        cmd.scan_eval = 1'b1;
        state_next = S_DRAIN2;
      end
      S_DRAIN2: begin
        cmd.scan_eval = 1'b1;
        state_next = S_BMUL;
      end
      S_BMUL: begin
        cmd.blend_mul = 1'b1;
        state_next = S_BFIX;
      end
      S_BFIX: begin
        cmd.blend_fix = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

[sv/lnna_datapath.sv]
// Datapath: CORDIC, position, table scan, blend, table update and result register.
module lnna_datapath
  import lnna_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  lnna_cmd_t               cmd,
  output lnna_status_t            status,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic [1:0]              cone_colour,
  input  logic [RANGE_W-1:0]      obs_range,
  input  logic signed [ANG_W-1:0] obs_bearing,
  input  logic signed [POS_W-1:0] pose_x,
  input  logic signed [POS_W-1:0] pose_y,
  input  logic signed [ANG_W-1:0] pose_heading,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              outcome,
  output logic [7:0]              entry_index,
  output logic signed [POS_W-1:0] landmark_x,
  output logic signed [POS_W-1:0] landmark_y
);
  logic [RANGE_W-1:0] range_cap;
  logic [THR_W-1:0] small_threshold, large_threshold;
  logic [WEIGHT_W-1:0] blend_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_cap <= 17'd20480;
      small_threshold <= 16'd1024;
      large_threshold <= 16'd2048;
      blend_weight <= 17'd52429;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RANGE_LIMIT: range_cap <= cfg_data[RANGE_W-1:0];
        REG_SMALL_THR: small_threshold <= cfg_data[THR_W-1:0];
        REG_LARGE_THR: large_threshold <= cfg_data[THR_W-1:0];
        REG_BLEND_WEIGHT: blend_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [1:0] colour;
  logic [RANGE_W-1:0] range_q;
  logic signed [POS_W-1:0] px, py;
  logic ignore_q;
  logic signed [ANG_W-1:0] angle;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      colour <= cone_colour;
      range_q <= obs_range;
      px <= pose_x;
      py <= pose_y;
      angle <= obs_bearing + pose_heading;
      ignore_q <= (obs_range >= range_cap) || (32'(cone_colour) >= COLOUR_COUNT);
    end
  end
  assign status.ignore = ignore_q;

  // CORDIC rotation, one step per cycle.
  logic signed [CORDIC_W-1:0] cx, cy, cz;
  logic neg;
  logic [STEP_W-1:0] cstep;
  logic signed [ANG_W-1:0] a_fold;
  logic a_neg;

  always_comb begin
    a_fold = angle;
    a_neg = 1'b0;
    if (angle > 16'sd16384) begin
      a_fold = angle - 16'sh8000;
      a_neg = 1'b1;
    end else if (angle < -16'sd16384) begin
      a_fold = angle + 16'sh8000;
      a_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cstep <= '0;
    end
    if (cmd.cordic_step) begin
      if (cstep == '0) begin
        // First step starts from the folded angle.
        if (!a_fold[ANG_W-1]) begin
          cx <= CORDIC_ONE;
          cy <= CORDIC_ONE;
          cz <= {{2{a_fold[ANG_W-1]}}, a_fold, 16'd0} - atan_entry('0);
        end else begin
          cx <= CORDIC_ONE;
          cy <= -CORDIC_ONE;
          cz <= {{2{a_fold[ANG_W-1]}}, a_fold, 16'd0} + atan_entry('0);
        end
        neg <= a_neg;
      end else if (!cz[CORDIC_W-1]) begin
        cx <= cx - (cy >>> cstep);
        cy <= cy + (cx >>> cstep);
        cz <= cz - atan_entry(cstep);
      end else begin
        cx <= cx + (cy >>> cstep);
        cy <= cy - (cx >>> cstep);
        cz <= cz + atan_entry(cstep);
      end
      cstep <= cstep + 1'b1;
    end
  end

  // Offsets: one multiplier used for x then y.
  logic signed [CORDIC_W-1:0] mul_b;
  logic signed [52:0] prod, prod_round;
  logic signed [POS_W+3:0] dx, dy;
  logic signed [CORDIC_W-1:0] cos_v, sin_v;
  assign cos_v = neg ? -cx : cx;
  assign sin_v = neg ? -cy : cy;
  assign mul_b = cmd.mul_x ? cos_v : sin_v;
  assign prod = $signed({1'b0, range_q}) * mul_b;
  assign prod_round = (prod + 53'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (cmd.mul_x) dx <= prod_round[POS_W+3:0];
    if (cmd.mul_y) dy <= prod_round[POS_W+3:0];
  end

  logic signed [POS_W-1:0] ox, oy;
  always_ff @(posedge clk) begin
    if (cmd.obs_fix) begin
      ox <= sat_pos(40'(px) + 40'(dx));
      oy <= sat_pos(40'(py) + 40'(dy));
    end
  end

  // Entry counts per colour.
  logic [CNT_W-1:0] counts [COLOUR_COUNT];
  logic [CNT_W-1:0] count;
  logic [COL_W-1:0] col;
  assign col = colour[COL_W-1:0];
  assign count = counts[col];
  assign status.full = (count == CNT_W'(ENTRIES_PER_COLOUR));

  // Table scan: address issue, registered read, distance, compare.
  logic [CNT_W-1:0] scan_addr;
  logic [ADDR_W-1:0] raddr, waddr;
  logic signed [POS_W-1:0] rd_x, rd_y;
  logic rd_v;
  logic we;
  logic signed [POS_W-1:0] wx, wy;
  logic wver;
  logic [IDX_W-1:0] best_idx;

  assign status.scan_done = (scan_addr >= count);
  assign raddr = cmd.scan_issue && !status.scan_done ? {col, scan_addr[IDX_W-1:0]}
                                                      : {col, best_idx};

  lnna_ram #(.WIDTH(POS_W), .DEPTH(TABLE_DEPTH)) u_ram_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wx), .raddr(raddr), .rdata(rd_x));
  lnna_ram #(.WIDTH(POS_W), .DEPTH(TABLE_DEPTH)) u_ram_y (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wy), .raddr(raddr), .rdata(rd_y));
  lnna_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_ram_v (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wver), .raddr(raddr), .rdata(rd_v));

  logic rd_live;
  logic [IDX_W-1:0] rd_idx;
  logic signed [POS_W:0] ex, ey;
  logic [IDX_W-1:0] ex_idx;
  logic ex_live;
  logic [DIST_W-1:0] best2, d2;
  logic found;
  logic [THR_W-1:0] thr;

  assign thr = (32'(colour) == LARGE_COLOUR) ? large_threshold : small_threshold;
  assign d2 = DIST_W'(ex * ex) + DIST_W'(ey * ey);

  always_ff @(posedge clk) begin
    if (cmd.obs_fix) begin
      scan_addr <= '0;
      rd_live <= 1'b0;
      ex_live <= 1'b0;
      found <= 1'b0;
      best_idx <= '0;
      best2 <= DIST_W'(thr * thr);
    end else if (cmd.scan_eval) begin
      rd_live <= cmd.scan_issue && !status.scan_done;
      rd_idx <= scan_addr[IDX_W-1:0];
      if (cmd.scan_issue && !status.scan_done) scan_addr <= scan_addr + 1'b1;
      ex <= (POS_W+1)'(ox) - (POS_W+1)'(rd_x);
      ey <= (POS_W+1)'(oy) - (POS_W+1)'(rd_y);
      ex_idx <= rd_idx;
      ex_live <= rd_live;
      if (ex_live && d2 < best2) begin
        best2 <= d2;
        best_idx <= ex_idx;
        found <= 1'b1;
      end
    end
  end

  // Blend: products registered, then summed and rounded.
  logic [WEIGHT_W-1:0] w;
  logic signed [WEIGHT_W+POS_W+1:0] bx_old, bx_obs, by_old, by_obs;
  logic signed [POS_W-1:0] rx, ry;
  logic old_ver;
  logic signed [WEIGHT_W+POS_W+2:0] sx, sy;
  assign w = blend_weight > 17'd65536 ? 17'd65536 : blend_weight;
  assign sx = 40'(bx_old) + 40'(bx_obs) + 40'sd32768;
  assign sy = 40'(by_old) + 40'(by_obs) + 40'sd32768;

  always_ff @(posedge clk) begin
    if (cmd.blend_mul) begin
      bx_old <= $signed({1'b0, w}) * rd_x;
      by_old <= $signed({1'b0, w}) * rd_y;
      bx_obs <= $signed({1'b0, 17'd65536 - w}) * ox;
      by_obs <= $signed({1'b0, 17'd65536 - w}) * oy;
      old_ver <= rd_v;
    end
    if (cmd.blend_fix) begin
      rx <= sat_pos(40'(sx >>> 16));
      ry <= sat_pos(40'(sy >>> 16));
    end
  end

  // Table write at commit.
  always_comb begin
    we = 1'b0;
    waddr = {col, best_idx};
    wx = rx;
    wy = ry;
    wver = 1'b1;
    if (cmd.commit) begin
      if (found) begin
        we = 1'b1;
      end else if (!status.full) begin
        we = 1'b1;
        waddr = {col, count[IDX_W-1:0]};
        wx = ox;
        wy = oy;
        wver = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COLOUR_COUNT; c++) counts[c] <= '0;
    end else if (cmd.commit && !found && !status.full) begin
      counts[col] <= count + 1'b1;
    end
  end

  // Remembers whether the commit appended a new entry, as the count has moved on since.
  logic fresh;
  always_ff @(posedge clk) begin
    if (cmd.commit) fresh <= !found && !status.full;
  end

  // Result register.
  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (ignore_q) begin
        outcome <= OUT_IGNORED;
        entry_index <= '0;
        landmark_x <= '0;
        landmark_y <= '0;
      end else if (found) begin
        outcome <= old_ver ? OUT_MATCHED : OUT_VERIFIED;
        entry_index <= 8'(best_idx);
        landmark_x <= rx;
        landmark_y <= ry;
      end else if (fresh) begin
        outcome <= OUT_NEW;
        entry_index <= 8'(count - 1'b1);
        landmark_x <= ox;
        landmark_y <= oy;
      end else begin
        outcome <= OUT_FULL;
        entry_index <= '0;
        landmark_x <= ox;
        landmark_y <= oy;
      end
    end
  end
endmodule

[sv/landmark_nearest_neighbour_associate.sv]
// Landmark association: one cone observation in, one association result out.
// Input channel: in_valid/in_stall carry colour, range, bearing and robot pose.
// Output channel: out_valid/out_stall carry outcome, entry index and position.
// Configuration: cfg_write, cfg_index and cfg_data write the four registers;
// write only while the block is idle.
// An ignored observation goes straight from its range and colour check to
// the result register; any other passes through the CORDIC, the two offset
// multiplies, the position fix, the scan of the entries of that colour (at
// most 256, one table entry per cycle through the position memories' single
// read port), the blend and the table write. One item is in work at a time.
// Reset clears the entry counts and restores register defaults; the landmark
// memories are not cleared, as only entries below the count are read.
// A stalled result holds in the output register; the next item may be taken
// meanwhile and waits at its end until the register frees.
module landmark_nearest_neighbour_associate
  import lnna_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              cone_colour,
  input  logic [RANGE_W-1:0]      obs_range,
  input  logic signed [ANG_W-1:0] obs_bearing,
  input  logic signed [POS_W-1:0] pose_x,
  input  logic signed [POS_W-1:0] pose_y,
  input  logic signed [ANG_W-1:0] pose_heading,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              outcome,
  output logic [7:0]              entry_index,
  output logic signed [POS_W-1:0] landmark_x,
  output logic signed [POS_W-1:0] landmark_y
);
  lnna_cmd_t cmd;
  lnna_status_t status;

  lnna_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd));

  lnna_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cone_colour(cone_colour), .obs_range(obs_range), .obs_bearing(obs_bearing),
    .pose_x(pose_x), .pose_y(pose_y), .pose_heading(pose_heading),
    .out_valid(out_valid), .out_stall(out_stall), .outcome(outcome),
    .entry_index(entry_index), .landmark_x(landmark_x), .landmark_y(landmark_y));
endmodule

[sim/landmark_nearest_neighbour_associate_test.sv]
// Self-checking testbench for the landmark nearest-neighbour association block.
`timescale 1ns / 1ps

module landmark_nearest_neighbour_associate_test;
  import lnna_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SITES = 16;

  typedef struct {
    logic [1:0]              colour;
    logic [RANGE_W-1:0]      range;
    logic signed [ANG_W-1:0] bearing;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [ANG_W-1:0] heading;
  } sighting_t;

  typedef struct {
    logic [2:0]              outcome;
    logic [7:0]              index;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } association_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] cone_colour = '0;
  logic [RANGE_W-1:0] obs_range = '0;
  logic signed [ANG_W-1:0] obs_bearing = '0;
  logic signed [POS_W-1:0] pose_x = '0;
  logic signed [POS_W-1:0] pose_y = '0;
  logic signed [ANG_W-1:0] pose_heading = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] outcome;
  logic [7:0] entry_index;
  logic signed [POS_W-1:0] landmark_x;
  logic signed [POS_W-1:0] landmark_y;

  landmark_nearest_neighbour_associate dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Predictor state: registers and landmark tables.
  longint lim_range, thr_small, thr_large, weight;
  longint map_x [TABLE_DEPTH];
  longint map_y [TABLE_DEPTH];
  bit map_seen [TABLE_DEPTH];
  int map_count [COLOUR_COUNT];

  sighting_t pending_sightings[$];
  association_t awaited_associations[$];
  sighting_t current;
  int errors = 0;
  int cycles = 0;
  int outcome_tally [8];
  int site_x [4][SITES];
  int site_y [4][SITES];

  function automatic longint clamp_pos(input longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint atan_step(input int i);
    longint t [16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                       64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                       64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                       64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    return t[i];
  endfunction

  function automatic longint mix(input longint old, input longint seen, input longint w);
    return clamp_pos((w * old + (65536 - w) * seen + 32768) >>> 16);
  endfunction

  // Works out the association for one sighting and updates the tables.
  function automatic association_t associate(input sighting_t s);
    association_t r;
    logic signed [ANG_W-1:0] wrapped;
    longint a, x, y, z, nx, c, sn, ox, oy, thr, best2, d2, ex, ey, w;
    int best, base, cnt, k;
    bit flip;
    r = '{OUT_IGNORED, 8'd0, '0, '0};
    if (longint'(s.range) >= lim_range || int'(s.colour) >= COLOUR_COUNT) return r;
    wrapped = s.bearing + s.heading;
    a = wrapped;
    flip = 0;
    if (a > 16384) begin
      a -= 32768;
      flip = 1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    sn = flip ? -y : y;
    ox = clamp_pos(longint'(s.px) + ((longint'(s.range) * c + (64'sd1 <<< 29)) >>> 30));
    oy = clamp_pos(longint'(s.py) + ((longint'(s.range) * sn + (64'sd1 <<< 29)) >>> 30));
    thr = (s.colour == LARGE_COLOUR) ? thr_large : thr_small;
    best2 = thr * thr;
    best = -1;
    base = int'(s.colour) * ENTRIES_PER_COLOUR;
    cnt = map_count[s.colour];
    for (int i = 0; i < cnt; i++) begin
      ex = ox - map_x[base + i];
      ey = oy - map_y[base + i];
      d2 = ex * ex + ey * ey;
      if (d2 < best2) begin
        best2 = d2;
        best = i;
      end
    end
    if (best >= 0) begin
      k = base + best;
      w = (weight > 65536) ? 65536 : weight;
      r.outcome = map_seen[k] ? OUT_MATCHED : OUT_VERIFIED;
      map_seen[k] = 1;
      map_x[k] = mix(map_x[k], ox, w);
      map_y[k] = mix(map_y[k], oy, w);
      r.index = best[7:0];
      r.x = map_x[k][POS_W-1:0];
      r.y = map_y[k][POS_W-1:0];
    end else if (cnt < ENTRIES_PER_COLOUR) begin
      k = base + cnt;
      map_x[k] = ox;
      map_y[k] = oy;
      map_seen[k] = 0;
      map_count[s.colour] = cnt + 1;
      r.outcome = OUT_NEW;
      r.index = cnt[7:0];
      r.x = ox[POS_W-1:0];
      r.y = oy[POS_W-1:0];
    end else begin
      r.outcome = OUT_FULL;
      r.x = ox[POS_W-1:0];
      r.y = oy[POS_W-1:0];
    end
    return r;
  endfunction

  // No idling on either side during this window.
  function automatic bit calm();
    return cycles > 30000 && cycles < 90000;
  endfunction

  // Sender.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall)
        awaited_associations = {awaited_associations, associate(current)};
      if (!in_valid || !in_stall) begin
        if (pending_sightings.size() > 0 && (calm() || $urandom_range(99) >= 33)) begin
          current = pending_sightings.pop_front();
          cone_colour <= current.colour;
          obs_range <= current.range;
          obs_bearing <= current.bearing;
          pose_x <= current.px;
          pose_y <= current.py;
          pose_heading <= current.heading;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Receiver and checker.
  always @(posedge clk) begin
    association_t want;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_associations.size() == 0) begin
          report("unexpected item, outcome", outcome, -1);
        end else begin
          want = awaited_associations.pop_front();
          outcome_tally[want.outcome]++;
          if (outcome !== want.outcome) report("outcome", outcome, want.outcome);
          if (entry_index !== want.index) report("entry_index", entry_index, want.index);
          if (landmark_x !== want.x) report("landmark_x", landmark_x, want.x);
          if (landmark_y !== want.y) report("landmark_y", landmark_y, want.y);
        end
      end
      out_stall <= !calm() && $urandom_range(99) < 33;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout waiting for results");
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    case (idx)
      REG_RANGE_LIMIT: lim_range = value & 17'h1FFFF;
      REG_SMALL_THR: thr_small = value & 16'hFFFF;
      REG_LARGE_THR: thr_large = value & 16'hFFFF;
      REG_BLEND_WEIGHT: weight = value & 17'h1FFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 0;
  endtask

  task automatic configure(input longint lim, input longint sm, input longint lg,
                           input longint w);
    set_reg(REG_RANGE_LIMIT, lim);
    set_reg(REG_SMALL_THR, sm);
    set_reg(REG_LARGE_THR, lg);
    set_reg(REG_BLEND_WEIGHT, w);
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_sightings.size() > 0 || in_valid || awaited_associations.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic send(input int col, input longint rng, input longint brg,
                      input longint x, input longint y, input longint hdg);
    sighting_t s;
    s.colour = col[1:0];
    s.range = rng[RANGE_W-1:0];
    s.bearing = brg[ANG_W-1:0];
    s.px = x[POS_W-1:0];
    s.py = y[POS_W-1:0];
    s.heading = hdg[ANG_W-1:0];
    pending_sightings = {pending_sightings, s};
  endtask

  // Mostly repeat sightings of known cone sites, some far ones, some pure noise.
  task automatic send_random(input int n, input int max_range);
    int col, site, kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      col = $urandom_range(3);
      site = $urandom_range(SITES - 1);
      if (kind < 75)
        send(col, $urandom_range(max_range), $urandom, site_x[col][site] +
             $urandom_range(600) - 300, site_y[col][site] + $urandom_range(600) - 300,
             $urandom);
      else if (kind < 85)
        send(col, $urandom_range(131071), $urandom,
             longint'($urandom_range(1000000)) - 500000,
             longint'($urandom_range(1000000)) - 500000, $urandom);
      else
        send(col, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    for (int c = 0; c < 4; c++)
      for (int s = 0; s < SITES; s++) begin
        site_x[c][s] = int'($urandom_range(900000)) - 450000;
        site_y[c][s] = int'($urandom_range(900000)) - 450000;
      end
    lim_range = 20480;
    thr_small = 1024;
    thr_large = 2048;
    weight = 52429;
    for (int c = 0; c < COLOUR_COUNT; c++) map_count[c] = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: ignored ranges, extremes, saturation, match then verify.
    send(0, 20480, 0, 0, 0, 0);
    send(2, 131071, 0, 0, 0, 0);
    send(0, 0, 0, 0, 0, 0);
    send(0, 0, 0, 100, 50, 0);
    send(0, 0, 0, 100, 50, 0);
    send(0, 10, 0, 100, 50, 0);
    send(3, 20479, 0, 524287, 524287, 0);
    send(3, 20479, 16384, -524288, -524288, 16384);
    send(3, 20479, -32768, -524288, 524287, 0);
    send(1, 20479, 32767, 0, 0, 32767);
    send(1, 5000, -32768, 200000, -200000, -32768);
    send(1, 5000, 8192, 200000, -200000, 8192);
    send(2, 3000, 16385, -100000, 100000, 0);
    send(2, 3000, -16385, -100000, 100000, 0);
    send(3, 0, 0, 300000, 300000, 0);
    send(3, 1500, 0, 300000, 300000, 0);
    send(3, 2100, 0, 300000, 300000, 0);
    drain();

    configure(131071, 65535, 65535, 131071);
    send(0, 131070, 12345, 1000, -1000, -3000);
    send(0, 131070, 12345, 1000, -1000, -3000);
    send(0, 0, 0, 0, 0, 0);
    drain();

    configure(0, 1024, 2048, 0);
    send_random(20, 200);
    drain();

    // Fill one colour's table to capacity: nothing can match at threshold zero.
    configure(131071, 0, 0, 40000);
    for (int i = 0; i < 260; i++)
      send(1, $urandom_range(131071), $urandom, $urandom, $urandom, $urandom);
    drain();

    configure(20480, 1024, 2048, 52429);
    send_random(400, 200);
    drain();
    configure(131071, 3000, 65535, 65536);
    send_random(400, 2000);
    drain();
    configure(65536, 500, 1500, 0);
    send_random(350, 300);
    drain();
    configure($urandom_range(131071), $urandom_range(65535), $urandom_range(65535),
              $urandom_range(131071));
    send_random(400, 400);
    drain();

    $display("covered %0d ignored, %0d matched, %0d newly verified, %0d new, %0d full",
             outcome_tally[OUT_IGNORED], outcome_tally[OUT_MATCHED],
             outcome_tally[OUT_VERIFIED], outcome_tally[OUT_NEW], outcome_tally[OUT_FULL]);
    $display("across %0d register settings in %0d cycles", 8, cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
